@@ sv/amp_pkg.sv @@
package amp_pkg;

  localparam int MAX_MPDUS = 64;

  localparam int BytesW  = 16;
  localparam int SubW    = 17;
  localparam int PsduW   = 23;
  localparam int LenW    = 24;
  localparam int CntOutW = 7;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 23;
  localparam int QDepth  = 2;

  localparam logic [CfgIdxW-1:0] CfgMpduLimit = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxPsdu   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAirtime   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTones     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMcs       = 3'd4;

  typedef struct packed {
    logic              start;
    logic              elig;
    logic [BytesW-1:0] bytes;
    logic [SubW-1:0]   sub;
  } amp_item_t;

  typedef struct packed {
    logic               refuse_all;
    logic [LenW-1:0]    len_limit;
    logic [CntOutW-1:0] mpdu_limit;
  } amp_lim_t;

  // spectral efficiency times six, mcs already clamped to 11
  function automatic logic [5:0] eff6(input logic [3:0] mcs);
    logic [5:0] e;
    case (mcs)
      4'd0:    e = 6'd3;
      4'd1:    e = 6'd6;
      4'd2:    e = 6'd9;
      4'd3:    e = 6'd12;
      4'd4:    e = 6'd18;
      4'd5:    e = 6'd24;
      4'd6:    e = 6'd27;
      4'd7:    e = 6'd30;
      4'd8:    e = 6'd36;
      4'd9:    e = 6'd40;
      4'd10:   e = 6'd45;
      default: e = 6'd50;
    endcase
    return e;
  endfunction

endpackage

@@ sv/amp_budget.sv @@
module amp_budget import amp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  output amp_lim_t           lim_o,
  output logic               busy_o
);

  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhMul1 = 3'd1;
  localparam logic [2:0] PhMul2 = 3'd2;
  localparam logic [2:0] PhDiv  = 3'd3;
  localparam logic [2:0] PhFin  = 3'd4;

  localparam int P1W     = 34;
  localparam int P2W     = 40;
  localparam int DropW   = 13;           // 614400 = 75 << 13
  localparam int DivW    = P2W - DropW;
  localparam int RecipW  = 28;
  localparam int RecipSh = 34;
  // ceil(2^34 / 75), exact for every dividend below 2^27
  localparam logic [RecipW-1:0] Recip75 = 28'd229064923;
  localparam int ProdW   = DivW + RecipW;
  localparam int QuoW    = ProdW - RecipSh;

  logic [CntOutW-1:0] mpdu_limit_q;
  logic [PsduW-1:0]   max_psdu_q;
  logic [22:0]        airtime_q;
  logic [10:0]        tones_q;
  logic [3:0]         mcs_q;

  logic [2:0]         phase_q, phase_d;
  logic [P1W-1:0]     prod1_q;
  logic               neg_q;
  logic [DivW-1:0]    dvd_q;
  logic [QuoW-1:0]    quo_q;
  logic [LenW-1:0]    len_lim_q;

  logic [10:0]        tones_eff;
  logic [3:0]         mcs_eff;
  logic [22:0]        dlt;
  logic [P2W-1:0]     prod2;
  logic [ProdW-1:0]   prod3;

  assign tones_eff = (tones_q < 11'd26) ? 11'd26 : tones_q;
  assign mcs_eff   = (mcs_q > 4'd11) ? 4'd11 : mcs_q;
  assign dlt       = airtime_q - 23'd48000;
  assign prod2     = P2W'(prod1_q) * P2W'(eff6(mcs_eff));

  // divide by 75 as a multiply by the rounded-up reciprocal
  assign prod3 = ProdW'(dvd_q) * ProdW'(Recip75);

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PhIdle:  phase_d = PhIdle;
      PhMul1:  phase_d = PhMul2;
      PhMul2:  phase_d = PhDiv;
      PhDiv:   phase_d = PhFin;
      PhFin:   phase_d = PhIdle;
      default: phase_d = PhIdle;
    endcase
    if (cfg_valid_i) phase_d = PhMul1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpdu_limit_q <= 7'd16;
      max_psdu_q   <= 23'd6500631;
      airtime_q    <= 23'd5484000;
      tones_q      <= 11'd26;
      mcs_q        <= 4'd0;
      phase_q      <= PhMul1;
      neg_q        <= 1'b0;
      len_lim_q    <= '0;
    end else begin
      phase_q <= phase_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgMpduLimit: mpdu_limit_q <= cfg_data_i[CntOutW-1:0];
          CfgMaxPsdu:   max_psdu_q   <= cfg_data_i;
          CfgAirtime:   airtime_q    <= cfg_data_i;
          CfgTones:     tones_q      <= cfg_data_i[10:0];
          CfgMcs:       mcs_q        <= cfg_data_i[3:0];
          default:      ;
        endcase
      end
      case (phase_q)
        PhMul1:  neg_q <= airtime_q < 23'd48000;
        PhFin:   len_lim_q <= (LenW'(quo_q) < LenW'(max_psdu_q)) ? LenW'(quo_q)
                                                                : LenW'(max_psdu_q);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      PhMul1:  prod1_q <= P1W'(dlt) * P1W'(tones_eff);
      PhMul2:  dvd_q <= prod2[P2W-1:DropW];
      PhDiv:   quo_q <= prod3[ProdW-1:RecipSh];
      default: ;
    endcase
  end

  assign lim_o.refuse_all = neg_q;
  assign lim_o.len_limit  = len_lim_q;
  assign lim_o.mpdu_limit = mpdu_limit_q;
  assign busy_o           = phase_q != PhIdle;

endmodule

@@ sv/amp_front.sv @@
module amp_front import amp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              hold_i,
  input  logic              in_valid_i,
  input  logic              start_req_i,
  input  logic              eligible_i,
  input  logic [BytesW-1:0] mpdu_bytes_i,
  output logic              in_ready_o,
  output logic              item_valid_o,
  output amp_item_t         item_o,
  input  logic              item_pop_i
);

  localparam int QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW = $clog2(QDepth + 1);

  amp_item_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;
  logic             push;
  amp_item_t        item_in;

  assign in_ready_o = !hold_i && (count_q < QCntW'(QDepth));
  assign push       = in_valid_i && in_ready_o;

  // padded subframe: delimiter plus length rounded up to 4 bytes
  always_comb begin
    item_in.start = start_req_i;
    item_in.elig  = eligible_i;
    item_in.bytes = mpdu_bytes_i;
    item_in.sub   = (SubW'(mpdu_bytes_i) + SubW'(7)) & ~SubW'(3);
  end

  always_comb begin
    count_d = count_q;
    if (push && !item_pop_i) count_d = count_q + QCntW'(1);
    if (!push && item_pop_i) count_d = count_q - QCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (item_pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= item_in;
  end

  assign item_valid_o = count_q != '0;
  assign item_o       = mem_q[rd_ptr_q];

endmodule

@@ sv/amp_back.sv @@
module amp_back import amp_pkg::*; #(
  parameter int MaxMpdus = MAX_MPDUS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  amp_lim_t           lim_i,
  input  logic               item_valid_i,
  input  amp_item_t          item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               accepted_o,
  output logic               closed_o,
  output logic [PsduW-1:0]   psdu_bytes_o,
  output logic [CntOutW-1:0] mpdu_count_o
);

  localparam int CntW = $clog2(MaxMpdus + 1);
  localparam int LimW = (CntW > CntOutW) ? CntW : CntOutW;

  logic [CntW-1:0]    cnt_q, cnt_d, c0;
  logic [PsduW-1:0]   pp_q, pp_d, pp0;
  logic [PsduW-1:0]   cl_q, cl_d, cl0;
  logic               done_q, done_d, done0;
  logic               acc_d;

  logic               out_valid_q;
  logic               acc_q, closed_q;
  logic [PsduW-1:0]   psdu_q;
  logic [CntOutW-1:0] cnt_out_q;

  logic [LimW-1:0]    eff_lim;
  logic [LenW-1:0]    prop, pp_sum;
  logic [CntW-1:0]    c1;

  assign item_pop_o = item_valid_i && (!out_valid_q || out_ready_i);

  assign eff_lim = (LimW'(lim_i.mpdu_limit) > LimW'(MaxMpdus)) ? LimW'(MaxMpdus)
                                                               : LimW'(lim_i.mpdu_limit);

  always_comb begin
    c0    = item_i.start ? '0 : cnt_q;
    pp0   = item_i.start ? '0 : pp_q;
    cl0   = item_i.start ? '0 : cl_q;
    done0 = item_i.start ? 1'b0 : done_q;
    // count limit reached, also covers a lowered limit
    if (LimW'(c0) >= eff_lim) done0 = 1'b1;

    prop   = (c0 == '0) ? LenW'(item_i.bytes)
                        : LenW'(pp0) + LenW'(4) + LenW'(item_i.bytes);
    pp_sum = LenW'(pp0) + LenW'(item_i.sub);
    c1     = c0 + CntW'(1);

    cnt_d  = c0;
    pp_d   = pp0;
    cl_d   = cl0;
    done_d = done0;
    acc_d  = 1'b0;
    if (!done0 && item_i.elig) begin
      if (lim_i.refuse_all || (prop > lim_i.len_limit)) begin
        done_d = 1'b1;
      end else begin
        acc_d  = 1'b1;
        cnt_d  = c1;
        cl_d   = prop[PsduW-1:0];
        pp_d   = pp_sum[PsduW] ? '1 : pp_sum[PsduW-1:0];
        done_d = LimW'(c1) >= eff_lim;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pp_q        <= '0;
      cl_q        <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_pop_o) begin
        cnt_q  <= cnt_d;
        pp_q   <= pp_d;
        cl_q   <= cl_d;
        done_q <= done_d;
      end
      if (item_pop_o) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      acc_q     <= acc_d;
      closed_q  <= done_d;
      psdu_q    <= cl_d;
      cnt_out_q <= CntOutW'(cnt_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign accepted_o   = acc_q;
  assign closed_o     = closed_q;
  assign psdu_bytes_o = psdu_q;
  assign mpdu_count_o = cnt_out_q;

endmodule

@@ sv/ampdu_packing_admission.sv @@
// a candidate's result is shown in the cycle after the one it sits at the queue head if the
// output is free (from an empty queue it first passes the queue register); one candidate per
// cycle is taken while output and budget do not hold it, set by the combinational length/count
// compare and accumulate in the back end; after reset and every configuration write the airtime
// budget is rebuilt (two multiplies, one reciprocal multiply, one select), no input until done
// reset is asynchronous active low and empties the aggregate and loads the register defaults
module ampdu_packing_admission import amp_pkg::*; #(
  parameter int MaxMpdus = MAX_MPDUS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               start_req_i,
  input  logic               eligible_i,
  input  logic [BytesW-1:0]  mpdu_bytes_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               accepted_o,
  output logic               closed_o,
  output logic [PsduW-1:0]   psdu_bytes_o,
  output logic [CntOutW-1:0] mpdu_count_o
);

  amp_lim_t  lim;
  logic      busy;
  logic      item_valid, item_pop;
  amp_item_t item;

  assign cfg_ready_o = 1'b1;

  amp_budget u_budget (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .lim_o       (lim),
    .busy_o      (busy)
  );

  amp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hold_i       (busy),
    .in_valid_i   (in_valid_i),
    .start_req_i  (start_req_i),
    .eligible_i   (eligible_i),
    .mpdu_bytes_i (mpdu_bytes_i),
    .in_ready_o   (in_ready_o),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  amp_back #(
    .MaxMpdus (MaxMpdus)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lim_i        (lim),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .accepted_o   (accepted_o),
    .closed_o     (closed_o),
    .psdu_bytes_o (psdu_bytes_o),
    .mpdu_count_o (mpdu_count_o)
  );

endmodule
